>>> hw/rtl/page_bitmap_allocator_core_assert.svh
// Assertion macros shared by the checker modules of the page bitmap allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pba_pkg.sv
package pba_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_PAGE_COUNT_DEF     = 131072;
  localparam int WORD_BITS_DEF          = 32;
  localparam int LOW_RESERVED_PAGES_DEF = 256;

  // Fixed field widths of the ports.
  localparam int CFG_W      = 18;
  localparam int ADDR_W     = 29;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] MANAGED_PAGES_RST   = CFG_W'(131072);
  localparam logic [CFG_W-1:0] KERNEL_END_PAGE_RST = CFG_W'(256);

  // Configuration register indexes.
  localparam logic CFG_MANAGED_PAGES   = 1'b0;
  localparam logic CFG_KERNEL_END_PAGE = 1'b1;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ALLOC,
    ST_FREE_DIV,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_RESP
  } state_t;

endpackage

>>> hw/rtl/pba_bitmap_ram.sv
module pba_bitmap_ram #(
  parameter int WIDTH = pba_pkg::WORD_BITS_DEF,
  parameter int DEPTH = pba_pkg::MAX_PAGE_COUNT_DEF / pba_pkg::WORD_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/pba_divider.sv
module pba_divider #(
  parameter int DIVISOR = pba_pkg::WORD_BITS_DEF,
  parameter int REM_W   = $clog2(DIVISOR)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pba_pkg::PAGE_NUM_W-1:0] dividend,
  output logic                           done,
  output logic [pba_pkg::PAGE_NUM_W-1:0] quotient,
  output logic [REM_W-1:0]               remainder
);

  localparam int          NW     = pba_pkg::PAGE_NUM_W;
  localparam int          LOG_D  = $clog2(DIVISOR);
  localparam int          SHIFT  = NW + LOG_D;
  localparam int          PROD_W = 2 * NW + 1;
  localparam logic [NW:0] RECIP  =
    (NW + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic              step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     dvd_r, dvd_nxt;
  logic [NW-1:0]     quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_shr;
  logic [NW-1:0]     back;

  // Division by the constant DIVISOR through multiplication with its
  // rounded-up reciprocal, exact for every NW-bit dividend. The quotient is
  // registered first, and the remainder and done follow from the registered quotient.
  always_comb begin
    prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    prod_shr = prod >> SHIFT;
    back     = quo_r * NW'(DIVISOR);
    step_nxt = 1'b0;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      step_nxt = 1'b1;
      dvd_nxt  = dividend;
      quo_nxt  = prod_shr[NW-1:0];
    end else if (step_r) begin
      rem_nxt  = REM_W'(dvd_r - back);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/page_bitmap_allocator_core.sv
// First-fit page-frame allocator over a bitmap of 4 KiB pages (set bit = used).
// Input channel (in_valid/in_ready) carries one command: init, allocate or free.
// Result channel (out_valid/out_ready) returns one result per command with the
// status, the allocated byte address and the free page count.
// The configuration port (cfg_we/cfg_index/cfg_wdata) sets the managed page
// count and the kernel end page; writes take effect at once.
// The bitmap lives in a single-port-write, registered-read memory of
// MAX_PAGE_COUNT / WORD_BITS words, and all commands share its one read port.
// Steps from input transfer to result valid:
//   init:     one bitmap word written per cycle, then the result.
//   allocate: one word read per cycle until a word with a free bit is found or
//             the whole words below the limit run out.
//   free:     the page to word/bit split, one read, one check and write-back,
//             then the result (straight to the result if out of range).
// One command is in flight at a time; in_ready is low from the input transfer
// until the result transfer completes. A stalled receiver holds the result in
// the output register and the block waits.
// After reset the block sweeps the whole bitmap to all ones before it raises
// in_ready.
module page_bitmap_allocator_core #(
  parameter int MAX_PAGE_COUNT     = pba_pkg::MAX_PAGE_COUNT_DEF,
  parameter int WORD_BITS          = pba_pkg::WORD_BITS_DEF,
  parameter int LOW_RESERVED_PAGES = pba_pkg::LOW_RESERVED_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pba_pkg::FUNC_W-1:0]   in_func,
  input  logic [pba_pkg::ADDR_W-1:0]   in_free_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pba_pkg::STATUS_W-1:0] out_status,
  output logic [pba_pkg::ADDR_W-1:0]   out_page_address,
  output logic [pba_pkg::CFG_W-1:0]    out_free_count,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int W          = WORD_BITS;
  localparam int WORD_COUNT = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int IDX_W      = $clog2(WORD_COUNT + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int SPAN       = WORD_COUNT * WORD_BITS + WORD_BITS;
  localparam int SPAN_W     = $clog2(SPAN + 1);
  localparam int CMP_W      = (SPAN_W > pba_pkg::CFG_W + 1) ? SPAN_W : pba_pkg::CFG_W + 1;
  localparam int CW         = pba_pkg::CFG_W;
  localparam int NW         = pba_pkg::PAGE_NUM_W;

  pba_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               managed_r, kernel_r;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [CMP_W-1:0]            base_r, base_nxt;
  logic                        pend_r, pend_nxt;
  logic [WIDX_W-1:0]           pidx_r, pidx_nxt;
  logic [CMP_W-1:0]            pbase_r, pbase_nxt;
  logic [BIT_W-1:0]            bit_r, bit_nxt;
  logic [CW-1:0]               free_cnt_r, free_cnt_nxt;
  logic [pba_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [pba_pkg::ADDR_W-1:0]  page_addr_r, page_addr_nxt;

  logic [CMP_W-1:0]  limit, res_raw, res, base_end, found_page;
  logic [W-1:0]      ones, one_bit, lo_keep, hi_keep, init_word;
  logic [W-1:0]      rdata, wdata;
  logic [WIDX_W-1:0] waddr;
  logic              we;
  logic              found, more;
  logic [BIT_W-1:0]  zpos;
  logic [NW-1:0]     free_page;
  logic              free_oor;
  logic              in_xfer;
  logic              div_start, div_done;
  logic [NW-1:0]     div_quo;
  logic [BIT_W-1:0]  div_rem;

  assign ones    = {W{1'b1}};
  assign one_bit = {{(W - 1){1'b0}}, 1'b1};
  assign in_xfer = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r <= pba_pkg::MANAGED_PAGES_RST;
      kernel_r  <= pba_pkg::KERNEL_END_PAGE_RST;
    end else if (cfg_we) begin
      if (cfg_index == pba_pkg::CFG_MANAGED_PAGES) begin
        managed_r <= cfg_wdata;
      end else begin
        kernel_r <= cfg_wdata;
      end
    end
  end

  // Managed limit and reserved area, both read live from the registers.
  always_comb begin
    limit   = (CMP_W'(managed_r) < CMP_W'(MAX_PAGE_COUNT)) ? CMP_W'(managed_r)
                                                           : CMP_W'(MAX_PAGE_COUNT);
    res_raw = (CMP_W'(kernel_r) > CMP_W'(LOW_RESERVED_PAGES)) ? CMP_W'(kernel_r)
                                                              : CMP_W'(LOW_RESERVED_PAGES);
    res     = (res_raw > limit) ? limit : res_raw;
  end

  // Init word for the word starting at base_r: a bit is free when its page
  // lies in the range from the reserved end up to the limit.
  assign base_end = base_r + CMP_W'(W);

  always_comb begin
    if (res <= base_r) begin
      lo_keep = ones;
    end else if (res >= base_end) begin
      lo_keep = '0;
    end else begin
      lo_keep = ones << BIT_W'(res - base_r);
    end
    if (limit >= base_end) begin
      hi_keep = ones;
    end else if (limit <= base_r) begin
      hi_keep = '0;
    end else begin
      hi_keep = ~(ones << BIT_W'(limit - base_r));
    end
    init_word = ~(lo_keep & hi_keep);
  end

  // Lowest clear bit of the word read during the allocation scan.
  always_comb begin
    zpos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (!rdata[j]) begin
        zpos = BIT_W'(j);
      end
    end
  end

  assign found      = pend_r && (rdata != ones);
  assign more       = base_end <= limit;
  assign found_page = pbase_r + CMP_W'(zpos);

  // Page number of a free request and its range check.
  assign free_page = in_free_address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
  assign free_oor  = CMP_W'(free_page) >= limit;

  // Sequencer: next state, memory control and result fields.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    pbase_nxt     = pbase_r;
    bit_nxt       = bit_r;
    free_cnt_nxt  = free_cnt_r;
    status_nxt    = status_r;
    page_addr_nxt = page_addr_r;
    we            = 1'b0;
    waddr         = idx_r[WIDX_W-1:0];
    wdata         = init_word;
    div_start     = 1'b0;
    case (state_r)
      pba_pkg::ST_CLEAR: begin
        we      = 1'b1;
        wdata   = ones;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(WORD_COUNT - 1)) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      pba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt       = '0;
          base_nxt      = '0;
          pend_nxt      = 1'b0;
          status_nxt    = pba_pkg::STATUS_OK;
          page_addr_nxt = '0;
          case (in_func)
            pba_pkg::FUNC_INIT: begin
              state_nxt = pba_pkg::ST_INIT;
            end
            pba_pkg::FUNC_ALLOC: begin
              state_nxt = pba_pkg::ST_ALLOC;
            end
            pba_pkg::FUNC_FREE: begin
              if (free_oor) begin
                status_nxt = pba_pkg::STATUS_OUT_OF_RANGE;
                state_nxt  = pba_pkg::ST_RESP;
              end else begin
                div_start = 1'b1;
                state_nxt = pba_pkg::ST_FREE_DIV;
              end
            end
            default: begin
              state_nxt = pba_pkg::ST_RESP;
            end
          endcase
        end
      end
      pba_pkg::ST_INIT: begin
        we       = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        base_nxt = base_end;
        if (idx_r == IDX_W'(WORD_COUNT - 1)) begin
          free_cnt_nxt = CW'(limit - res);
          state_nxt    = pba_pkg::ST_RESP;
        end
      end
      pba_pkg::ST_ALLOC: begin
        if (found) begin
          we            = 1'b1;
          waddr         = pidx_r;
          wdata         = rdata | (one_bit << zpos);
          free_cnt_nxt  = free_cnt_r - CW'(1);
          page_addr_nxt = {found_page[NW-1:0], {pba_pkg::PAGE_SHIFT{1'b0}}};
          state_nxt     = pba_pkg::ST_RESP;
        end else if (more) begin
          // The read of word idx_r is under way; its data is checked next cycle.
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[WIDX_W-1:0];
          pbase_nxt = base_r;
          idx_nxt   = idx_r + IDX_W'(1);
          base_nxt  = base_end;
        end else begin
          status_nxt = pba_pkg::STATUS_NO_FREE;
          state_nxt  = pba_pkg::ST_RESP;
        end
      end
      pba_pkg::ST_FREE_DIV: begin
        if (div_done) begin
          idx_nxt   = IDX_W'(div_quo);
          bit_nxt   = div_rem;
          state_nxt = pba_pkg::ST_FREE_RD;
        end
      end
      pba_pkg::ST_FREE_RD: begin
        state_nxt = pba_pkg::ST_FREE_CHK;
      end
      pba_pkg::ST_FREE_CHK: begin
        if (!rdata[bit_r]) begin
          status_nxt = pba_pkg::STATUS_ALREADY_FREE;
        end else begin
          we           = 1'b1;
          wdata        = rdata & ~(one_bit << bit_r);
          free_cnt_nxt = free_cnt_r + CW'(1);
        end
        state_nxt = pba_pkg::ST_RESP;
      end
      pba_pkg::ST_RESP: begin
        if (out_ready) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pba_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pba_pkg::ST_CLEAR;
      idx_r      <= '0;
      pend_r     <= 1'b0;
      free_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
      free_cnt_r <= free_cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    pidx_r      <= pidx_nxt;
    pbase_r     <= pbase_nxt;
    bit_r       <= bit_nxt;
    status_r    <= status_nxt;
    page_addr_r <= page_addr_nxt;
  end

  pba_bitmap_ram #(
    .WIDTH (W),
    .DEPTH (WORD_COUNT),
    .AW    (WIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[WIDX_W-1:0]),
    .rdata (rdata)
  );

  pba_divider #(
    .DIVISOR (W),
    .REM_W   (BIT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (free_page),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ready         = (state_r == pba_pkg::ST_IDLE);
  assign out_valid        = (state_r == pba_pkg::ST_RESP);
  assign out_status       = status_r;
  assign out_page_address = page_addr_r;
  assign out_free_count   = free_cnt_r;

endmodule

>>> hw/rtl/pba_checker.sv
`include "page_bitmap_allocator_core_assert.svh"

module pba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pba_pkg::STATUS_W-1:0] out_status,
  input logic [pba_pkg::ADDR_W-1:0]   out_page_address,
  input logic [pba_pkg::CFG_W-1:0]    out_free_count
);

  // A result held by a stalled receiver does not change.
  `PBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_page_address) && $stable(out_free_count), "result changed while stalled")

  // Only one command is in flight: no new input while a result waits.
  `PBA_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "input ready while result pending")

  // In the cycle after an input transfer the block is busy.
  `PBA_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input ready right after transfer")

  // Only a successful command carries a page address.
  `PBA_ASSERT_NOW(a_addr_zero_on_fail, out_valid && (out_status != pba_pkg::STATUS_OK), out_page_address == '0, "address given on failed command")

  // Returned addresses are page aligned.
  `PBA_ASSERT_NOW(a_addr_aligned, out_valid, out_page_address[pba_pkg::PAGE_SHIFT-1:0] == '0, "page address not aligned")

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (.*);

>>> tb/pba_result_checker.sv
module pba_result_checker
  import pba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ADDR_W-1:0]   in_free_address,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [ADDR_W-1:0]   out_page_address,
  input  logic [CFG_W-1:0]    out_free_count,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output int                  pending_results,
  output int                  fail_count,
  output int                  checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_TOTAL   = MAX_PAGE_COUNT_DEF;
  localparam int WORD_TOTAL   = PAGE_TOTAL / WORD_BITS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [CFG_W-1:0]    free_count;
  } alloc_result_t;

  // Shadow copy of the allocator: usage bitmap (set = used), free count, registers.
  logic [WORD_BITS_DEF-1:0] usage_words [WORD_TOTAL];
  logic [CFG_W-1:0]         shadow_free_count;
  logic [CFG_W-1:0]         managed_pages_reg;
  logic [CFG_W-1:0]         kernel_end_reg;
  alloc_result_t            expected_results [$];

  // Print one line per failure and count it.
  task automatic report_failure(input string msg);
    $display("ERROR %0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  // Apply one command to the shadow state and return the result it must produce.
  function automatic alloc_result_t predict_command(input logic [FUNC_W-1:0] func,
                                                    input logic [ADDR_W-1:0] addr);
    alloc_result_t result;
    int unsigned   limit;
    int unsigned   first_free;
    int unsigned   page;
    int unsigned   word_idx;
    int unsigned   bit_idx;
    logic          found;
    result = '0;
    result.status = STATUS_OK;
    // The limit follows the register at every command; it is not latched at init.
    limit = (managed_pages_reg < PAGE_TOTAL) ? managed_pages_reg : PAGE_TOTAL;
    case (func)
      FUNC_INIT: begin
        // The reserved area is clamped to the limit, so the count never underflows.
        first_free = (kernel_end_reg > LOW_RESERVED_PAGES_DEF) ?
                     kernel_end_reg : LOW_RESERVED_PAGES_DEF;
        if (first_free > limit) begin
          first_free = limit;
        end
        foreach (usage_words[w]) usage_words[w] = '1;
        for (page = first_free; page < limit; page++) begin
          usage_words[page / WORD_BITS_DEF][page % WORD_BITS_DEF] = 1'b0;
        end
        shadow_free_count = CFG_W'(limit - first_free);
      end
      FUNC_ALLOC: begin
        found = 1'b0;
        // Only whole words below the limit are searched, lowest page first.
        for (word_idx = 0; word_idx < limit / WORD_BITS_DEF && !found; word_idx++) begin
          if (usage_words[word_idx] != '1) begin
            for (bit_idx = 0; bit_idx < WORD_BITS_DEF && !found; bit_idx++) begin
              if (!usage_words[word_idx][bit_idx]) begin
                page = word_idx * WORD_BITS_DEF + bit_idx;
                usage_words[word_idx][bit_idx] = 1'b1;
                shadow_free_count = shadow_free_count - 1'b1;
                result.page_address = ADDR_W'(page) << PAGE_SHIFT;
                found = 1'b1;
              end
            end
          end
        end
        if (!found) begin
          result.status = STATUS_NO_FREE;
        end
      end
      FUNC_FREE: begin
        page = addr >> PAGE_SHIFT;
        if (page >= limit) begin
          result.status = STATUS_OUT_OF_RANGE;
        end else if (!usage_words[page / WORD_BITS_DEF][page % WORD_BITS_DEF]) begin
          result.status = STATUS_ALREADY_FREE;
        end else begin
          usage_words[page / WORD_BITS_DEF][page % WORD_BITS_DEF] = 1'b0;
          shadow_free_count = shadow_free_count + 1'b1;
        end
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    result.free_count = shadow_free_count;
    return result;
  endfunction

  // Track register writes, predict on each command transfer and check each result transfer.
  always @(posedge clk) begin : watch_channels
    alloc_result_t want;
    if (!rst_n) begin
      foreach (usage_words[w]) usage_words[w] = '1;
      shadow_free_count = '0;
      managed_pages_reg = MANAGED_PAGES_RST;
      kernel_end_reg = KERNEL_END_PAGE_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MANAGED_PAGES) begin
          managed_pages_reg = cfg_wdata;
        end else begin
          kernel_end_reg = cfg_wdata;
        end
      end
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no command outstanding",
                                   checked_count));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            report_failure($sformatf("result %0d status: got %0d, expected %0d",
                                     checked_count, out_status, want.status));
          end
          if (out_page_address !== want.page_address) begin
            report_failure($sformatf("result %0d page_address: got 0x%0h, expected 0x%0h",
                                     checked_count, out_page_address, want.page_address));
          end
          if (out_free_count !== want.free_count) begin
            report_failure($sformatf("result %0d free_count: got %0d, expected %0d",
                                     checked_count, out_free_count, want.free_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_command(in_func, in_free_address));
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top
  import pba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_RESERVED   = 2'd3;
  localparam int unsigned       PAGE_TOTAL      = MAX_PAGE_COUNT_DEF;
  localparam logic [CFG_W-1:0]  CFG_ALL_ONES    = '1;
  localparam int                IDLE_LIMIT      = 20000;
  localparam int                HOLD_OFF_CYCLES = 300;
  localparam int                SETTLE_CYCLES   = 4;
  localparam int                DRAIN_CYCLES    = 4200;
  localparam int                RANDOM_PHASES   = 5;
  localparam int                PHASE_ITEMS     = 23;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
  } command_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func          = FUNC_INIT;
  logic [ADDR_W-1:0]   in_free_address  = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_page_address;
  logic [CFG_W-1:0]    out_free_count;
  logic                cfg_we           = 1'b0;
  logic                cfg_index        = CFG_MANAGED_PAGES;
  logic [CFG_W-1:0]    cfg_wdata        = '0;

  int          pending_results;
  int          fail_count;
  int          checked_count;
  command_t    command_plan [$];
  int          op_count [4];
  int          settings_written;
  int unsigned allocs_since_init;
  bit          hold_request;
  bit          sender_steady;

  page_bitmap_allocator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_free_count   (out_free_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  pba_result_checker u_result_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_free_count   (out_free_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending_results  (pending_results),
    .fail_count       (fail_count),
    .checked_count    (checked_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] page_to_addr(input int unsigned page,
                                                     input logic [PAGE_SHIFT-1:0] offset);
    return {page[PAGE_NUM_W-1:0], offset};
  endfunction

  // Queue one command; the count of allocs since init steers where frees land.
  task automatic plan(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr);
    command_plan.push_back('{func, addr});
    if (func == FUNC_INIT) begin
      allocs_since_init = 0;
    end else if (func == FUNC_ALLOC) begin
      allocs_since_init++;
    end
  endtask

  // Write both registers on back-to-back cycles while the block is idle.
  task automatic write_settings(input logic [CFG_W-1:0] pages, input logic [CFG_W-1:0] kend);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MANAGED_PAGES;
    cfg_wdata <= pages;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_END_PAGE;
    cfg_wdata <= kend;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // Offer the queued commands one transfer at a time, with random gaps between them.
  task automatic issue_commands();
    command_t cmd;
    int       gap;
    while (command_plan.size() > 0) begin
      cmd = command_plan.pop_front();
      in_valid <= 1'b1;
      in_func <= cmd.func;
      in_free_address <= cmd.addr;
      op_count[cmd.func]++;
      do @(posedge clk); while (!in_ready);
      if ($urandom_range(0, 15) == 0) begin
        sender_steady = !sender_steady;
      end
      gap = sender_steady ? 0 : $urandom_range(0, 15);
      // Valid stays up across back-to-back transfers.
      if (gap > 0 || command_plan.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Send the planned commands and wait until every result has come back.
  task automatic run_phase();
    issue_commands();
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random commands for one register setting, mostly allocs and frees of pages
  // handed out since the last init, plus out-of-range and arbitrary frees, some inits and the unused code.
  task automatic plan_random_phase(input logic [CFG_W-1:0] pages, input logic [CFG_W-1:0] kend,
                                   input bit start_with_init);
    int unsigned limit;
    int unsigned first_free;
    int unsigned pick;
    limit = (pages < PAGE_TOTAL) ? pages : PAGE_TOTAL;
    first_free = (kend > LOW_RESERVED_PAGES_DEF) ? kend : LOW_RESERVED_PAGES_DEF;
    if (first_free > limit) begin
      first_free = limit;
    end
    if (start_with_init) begin
      plan(FUNC_INIT, ADDR_W'($urandom()));
    end
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        plan(FUNC_INIT, ADDR_W'($urandom()));
      end else if (pick < 50) begin
        plan(FUNC_ALLOC, ADDR_W'($urandom()));
      end else if (pick < 85) begin
        plan(FUNC_FREE, page_to_addr(first_free + $urandom_range(0, allocs_since_init + 1),
                                     PAGE_SHIFT'($urandom())));
      end else if (pick < 93) begin
        plan(FUNC_FREE, page_to_addr((limit < PAGE_TOTAL) ?
                                     $urandom_range(limit, PAGE_TOTAL - 1) :
                                     $urandom_range(0, PAGE_TOTAL - 1),
                                     PAGE_SHIFT'($urandom())));
      end else if (pick < 97) begin
        plan(FUNC_FREE, ADDR_W'($urandom()));
      end else begin
        plan(FUNC_RESERVED, ADDR_W'($urandom()));
      end
    end
  endtask

  // Result side: random stalls per result, steady stretches, and one long hold-off.
  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        steady = !steady;
      end
      if (hold_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // The run ends as failed once no transfer has happened for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] pages;
    logic [CFG_W-1:0] kend;
    int unsigned      limit;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a free before any init, the unused code, then first-fit
    // allocation, double free, reuse of the lowest page and the top page.
    plan(FUNC_FREE, page_to_addr(1000, 12'hABC));
    plan(FUNC_RESERVED, '1);
    plan(FUNC_INIT, '0);
    repeat (3) plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, page_to_addr(257, '0));
    plan(FUNC_FREE, page_to_addr(257, 12'hFFF));
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, '1);
    run_phase();

    // Limit inside a word: the partial last word is never handed out, so the
    // fifth alloc fails while pages are still free; then out of range and reuse.
    write_settings(18'd1000, 18'd988);
    plan(FUNC_INIT, '0);
    repeat (5) plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, page_to_addr(995, '0));
    plan(FUNC_FREE, page_to_addr(1000, '0));
    plan(FUNC_FREE, page_to_addr(989, '0));
    plan(FUNC_ALLOC, '0);
    run_phase();

    // Lower the limit without an init: it applies at once.
    write_settings(18'd64, 18'd988);
    plan(FUNC_FREE, page_to_addr(100, '0));
    plan(FUNC_ALLOC, '0);
    run_phase();

    // Largest values: the limit saturates and the reserved area covers everything.
    write_settings(CFG_ALL_ONES, CFG_ALL_ONES);
    plan(FUNC_INIT, '0);
    plan(FUNC_ALLOC, '0);
    run_phase();

    // Nothing managed at all.
    write_settings('0, '0);
    plan(FUNC_INIT, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, '0);
    run_phase();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pages = CFG_W'($urandom_range(0, 2048));
        4, 5, 6:    pages = CFG_W'(PAGE_TOTAL);
        7, 8:       pages = CFG_W'($urandom());
        default:    pages = CFG_W'($urandom_range(32, 96));
      endcase
      limit = (pages < PAGE_TOTAL) ? pages : PAGE_TOTAL;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kend = CFG_W'($urandom_range(0, 600));
        6, 7, 8:          kend = CFG_W'($urandom_range(0, limit));
        default:          kend = CFG_W'($urandom());
      endcase
      write_settings(pages, kend);
      plan_random_phase(pages, kend, phase == 0 || $urandom_range(0, 3) != 0);
      // Hold results back so the sender stalls on a busy block.
      if (phase == 1) begin
        hold_request = 1'b1;
      end
      run_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d commands (%0d init, %0d alloc, %0d free, %0d unused code) under %0d register settings.",
             op_count[FUNC_INIT] + op_count[FUNC_ALLOC] + op_count[FUNC_FREE] +
             op_count[FUNC_RESERVED], op_count[FUNC_INIT], op_count[FUNC_ALLOC],
             op_count[FUNC_FREE], op_count[FUNC_RESERVED], settings_written);
    $display("%0d results compared field by field, %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
